// ===== rtl/tsv_pkg.sv =====
// shared types and constants for the tcp segment validator
// no dependencies
package tsv_pkg;

    localparam int QDEPTH = 2;

    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [15:0] MIN_LEN   = 16'd20;
    localparam logic [5:0]  MIN_HLEN  = 6'd20;
    localparam logic [7:0]  FLAG_MASK = 8'h3f;
    localparam logic [7:0]  SYN_FIN   = 8'h03;
    localparam logic [7:0]  RSV_MASK  = 8'h0f;
    localparam logic [15:0] CSUM_OK   = 16'hffff;
    localparam logic [15:0] POS_MAX   = 16'hffff;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_TCP   = 2'd1,
        ST_BAD_SIZE  = 2'd2,
        ST_INTEGRITY = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0]      acc;
        logic [15:0][7:0] cap;
        logic [15:0]      len;
        logic [7:0]       proto;
        logic [15:0]      off;
    } t_rec;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_sts;

endpackage

// ===== rtl/tsv_front.sv =====
// front end: byte capture, header bytes and pseudo-header checksum accumulation
// depends on tsv_pkg
module tsv_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last,
    input  logic [15:0]   i_segment_length,
    input  logic [7:0]    i_ip_protocol,
    input  logic [31:0]   i_source_address,
    input  logic [31:0]   i_destination_address,
    input  logic [15:0]   i_ip_payload_offset,
    output logic          o_push,
    output tsv_pkg::t_rec o_rec
);
    import tsv_pkg::*;

    logic [15:0]      r_pos;
    logic [31:0]      r_acc;
    logic [7:0]       r_pend;
    logic [15:0]      r_len;
    logic [7:0]       r_proto;
    logic [15:0]      r_off;
    logic [15:0][7:0] r_cap;

    logic             first;
    logic [15:0]      eff_len;
    logic [7:0]       eff_proto;
    logic [15:0]      eff_off;
    logic [31:0]      eff_acc;
    logic [7:0]       eff_pend;
    logic [31:0]      init_acc;
    logic             in_len;
    logic [15:0][7:0] n_cap;
    logic [7:0]       n_pend;
    logic [15:0]      n_pos;
    logic             odd_count;
    logic [15:0]      addend;
    logic [31:0]      n_acc;

    always_comb begin
        first     = (r_pos == 16'd0);
        init_acc  = {16'd0, i_source_address[31:16]} + {16'd0, i_source_address[15:0]}
                  + {16'd0, i_destination_address[31:16]}
                  + {16'd0, i_destination_address[15:0]}
                  + {24'd0, PROTO_TCP} + {16'd0, i_segment_length};
        eff_len   = first ? i_segment_length : r_len;
        eff_proto = first ? i_ip_protocol : r_proto;
        eff_off   = first ? i_ip_payload_offset : r_off;
        eff_acc   = first ? init_acc : r_acc;
        eff_pend  = first ? 8'd0 : r_pend;
        n_cap     = first ? '0 : r_cap;
        in_len    = (r_pos < eff_len);
        if (in_len && (r_pos[15:4] == 12'd0)) begin
            n_cap[r_pos[3:0]] = i_data_byte;
        end
        n_pend    = (in_len && !r_pos[0]) ? i_data_byte : eff_pend;
        n_pos     = (r_pos == POS_MAX) ? r_pos : r_pos + 16'd1;
        odd_count = (n_pos < eff_len) ? n_pos[0] : eff_len[0];
        if (in_len && r_pos[0]) begin
            addend = {eff_pend, i_data_byte};
        end else if (i_last && odd_count) begin
            addend = {n_pend, 8'd0};
        end else begin
            addend = 16'd0;
        end
        n_acc     = eff_acc + {16'd0, addend};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 16'd0;
        end else if (i_take) begin
            r_pos <= i_last ? 16'd0 : n_pos;
        end
    end

    // per-frame payload registers, only read once the frame is under way
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_acc   <= n_acc;
            r_pend  <= n_pend;
            r_cap   <= n_cap;
            r_len   <= eff_len;
            r_proto <= eff_proto;
            r_off   <= eff_off;
        end
    end

    assign o_push      = i_take && i_last;
    assign o_rec.acc   = n_acc;
    assign o_rec.cap   = n_cap;
    assign o_rec.len   = eff_len;
    assign o_rec.proto = eff_proto;
    assign o_rec.off   = eff_off;

endmodule

// ===== rtl/tsv_queue.sv =====
// small frame record queue between front and back ends
// depends on tsv_pkg
module tsv_queue #(
    parameter int DEPTH = tsv_pkg::QDEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tsv_pkg::t_q_ctl i_ctl,
    input  tsv_pkg::t_rec  i_rec,
    output tsv_pkg::t_q_sts o_sts,
    output tsv_pkg::t_rec  o_rec
);
    import tsv_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_sts.full  = (r_cnt == CW'(DEPTH));
    assign o_sts.empty = (r_cnt == '0);
    assign do_push     = i_ctl.push && !o_sts.full;
    assign do_pop      = i_ctl.pop && !o_sts.empty;
    assign o_rec       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

endmodule

// ===== rtl/tsv_back.sv =====
// back end: header checks and two-stage checksum fold into the result register
// depends on tsv_pkg
module tsv_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  tsv_pkg::t_rec  i_rec,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [1:0]     o_status,
    output logic [31:0]    o_sequence_number,
    output logic [31:0]    o_ack_number,
    output logic [15:0]    o_src_port,
    output logic [15:0]    o_dst_port,
    output logic [15:0]    o_window_size,
    output logic [15:0]    o_data_offset,
    output logic [15:0]    o_data_length,
    output logic [7:0]     o_tcp_flags,
    output logic [5:0]     o_header_bytes
);
    import tsv_pkg::*;

    logic        r_s1_vld;
    t_status     r_s1_status;
    logic [16:0] r_s1_fold;
    logic [31:0] r_s1_seq;
    logic [31:0] r_s1_ack;
    logic [15:0] r_s1_sport;
    logic [15:0] r_s1_dport;
    logic [15:0] r_s1_win;
    logic [15:0] r_s1_doff;
    logic [15:0] r_s1_dlen;
    logic [7:0]  r_s1_flags;
    logic [5:0]  r_s1_hlen;
    logic        r_out_vld;

    logic        out_adv;
    logic        s1_adv;
    logic [7:0]  b12;
    logic [5:0]  hlen;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  flags;
    t_status     n_s1_status;
    logic [16:0] fold2;
    logic [15:0] fold3;
    t_status     n_status;

    assign out_adv = !r_out_vld || i_pop;
    assign s1_adv  = !r_s1_vld || out_adv;
    assign o_q_pop = s1_adv && !i_q_empty;
    assign o_empty = !r_out_vld;

    always_comb begin
        b12   = i_rec.cap[12];
        hlen  = {b12[7:4], 2'b00};
        sport = {i_rec.cap[0], i_rec.cap[1]};
        dport = {i_rec.cap[2], i_rec.cap[3]};
        flags = i_rec.cap[13];
        if (i_rec.proto != PROTO_TCP) begin
            n_s1_status = ST_NOT_TCP;
        end else if (i_rec.len < MIN_LEN) begin
            n_s1_status = ST_BAD_SIZE;
        end else if (hlen < MIN_HLEN || {10'd0, hlen} > i_rec.len
                     || (b12 & RSV_MASK) != 8'd0) begin
            n_s1_status = ST_BAD_SIZE;
        end else if (sport == 16'd0 || dport == 16'd0 || (flags & ~FLAG_MASK) != 8'd0
                     || (flags & SYN_FIN) == SYN_FIN) begin
            n_s1_status = ST_INTEGRITY;
        end else begin
            n_s1_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_adv) begin
            r_s1_vld <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_status <= n_s1_status;
            r_s1_fold   <= {1'b0, i_rec.acc[15:0]} + {1'b0, i_rec.acc[31:16]};
            r_s1_seq    <= {i_rec.cap[4], i_rec.cap[5], i_rec.cap[6], i_rec.cap[7]};
            r_s1_ack    <= {i_rec.cap[8], i_rec.cap[9], i_rec.cap[10], i_rec.cap[11]};
            r_s1_sport  <= sport;
            r_s1_dport  <= dport;
            r_s1_win    <= {i_rec.cap[14], i_rec.cap[15]};
            r_s1_doff   <= i_rec.off + {10'd0, hlen};
            r_s1_dlen   <= i_rec.len - {10'd0, hlen};
            r_s1_flags  <= flags;
            r_s1_hlen   <= hlen;
        end
    end

    always_comb begin
        fold2 = {1'b0, r_s1_fold[15:0]} + {16'd0, r_s1_fold[16]};
        fold3 = fold2[15:0] + {15'd0, fold2[16]};
        if (r_s1_status == ST_OK && fold3 != CSUM_OK) begin
            n_status = ST_INTEGRITY;
        end else begin
            n_status = r_s1_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_vld) begin
            o_status <= n_status;
            if (n_status == ST_OK) begin
                o_sequence_number <= r_s1_seq;
                o_ack_number      <= r_s1_ack;
                o_src_port        <= r_s1_sport;
                o_dst_port        <= r_s1_dport;
                o_window_size     <= r_s1_win;
                o_data_offset     <= r_s1_doff;
                o_data_length     <= r_s1_dlen;
                o_tcp_flags       <= r_s1_flags;
                o_header_bytes    <= r_s1_hlen;
            end else begin
                o_sequence_number <= 32'd0;
                o_ack_number      <= 32'd0;
                o_src_port        <= 16'd0;
                o_dst_port        <= 16'd0;
                o_window_size     <= 16'd0;
                o_data_offset     <= 16'd0;
                o_data_length     <= 16'd0;
                o_tcp_flags       <= 8'd0;
                o_header_bytes    <= 6'd0;
            end
        end
    end

endmodule

// ===== rtl/tcp_segment_validator_unit.sv =====
// top level of the tcp segment validator: front end, record queue, back end
// depends on tsv_pkg, tsv_front, tsv_queue, tsv_back
//
// Takes one IP payload byte per cycle while full is low, with no gaps needed between
// frames. The first byte of a frame samples length, protocol, payload offset and
// addresses; the byte marked last closes the frame and yields one verdict, which
// reaches the result side after the two-stage checksum fold. Frame records wait in a
// QUEUE_DEPTH entry queue ahead of the fold stage and the result register, so full
// rises only when QUEUE_DEPTH + 2 verdicts are held back by a stalled result side.
module tcp_segment_validator_unit #(
    parameter int QUEUE_DEPTH = tsv_pkg::QDEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic [15:0] i_segment_length,
    input  logic [7:0]  i_ip_protocol,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_destination_address,
    input  logic [15:0] i_ip_payload_offset,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [31:0] o_sequence_number,
    output logic [31:0] o_ack_number,
    output logic [15:0] o_src_port,
    output logic [15:0] o_dst_port,
    output logic [15:0] o_window_size,
    output logic [15:0] o_data_offset,
    output logic [15:0] o_data_length,
    output logic [7:0]  o_tcp_flags,
    output logic [5:0]  o_header_bytes
);
    import tsv_pkg::*;

    t_rec   front_rec;
    t_rec   q_rec;
    t_q_ctl q_ctl;
    t_q_sts q_sts;
    logic   take;
    logic   front_push;
    logic   back_pop;

    assign full      = q_sts.full;
    assign take      = push && !q_sts.full;
    assign q_ctl.push = front_push;
    assign q_ctl.pop  = back_pop;

    tsv_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_take                (take),
        .i_data_byte           (i_data_byte),
        .i_last                (i_last),
        .i_segment_length      (i_segment_length),
        .i_ip_protocol         (i_ip_protocol),
        .i_source_address      (i_source_address),
        .i_destination_address (i_destination_address),
        .i_ip_payload_offset   (i_ip_payload_offset),
        .o_push                (front_push),
        .o_rec                 (front_rec)
    );

    tsv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .i_rec   (front_rec),
        .o_sts   (q_sts),
        .o_rec   (q_rec)
    );

    tsv_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_sts.empty),
        .i_rec             (q_rec),
        .o_q_pop           (back_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_status          (o_status),
        .o_sequence_number (o_sequence_number),
        .o_ack_number      (o_ack_number),
        .o_src_port        (o_src_port),
        .o_dst_port        (o_dst_port),
        .o_window_size     (o_window_size),
        .o_data_offset     (o_data_offset),
        .o_data_length     (o_data_length),
        .o_tcp_flags       (o_tcp_flags),
        .o_header_bytes    (o_header_bytes)
    );

endmodule

// ===== rtl/tsv_checker.sv =====
// port-level checks on the result side of the tcp segment validator
// depends on tsv_pkg; bound to tcp_segment_validator_unit
module tsv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_status,
    input logic [31:0] o_sequence_number,
    input logic [31:0] o_ack_number,
    input logic [15:0] o_src_port,
    input logic [15:0] o_dst_port,
    input logic [15:0] o_window_size,
    input logic [15:0] o_data_offset,
    input logic [15:0] o_data_length,
    input logic [7:0]  o_tcp_flags,
    input logic [5:0]  o_header_bytes
);
    import tsv_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting right after reset");

    a_error_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |->
        (o_sequence_number == 32'd0 && o_ack_number == 32'd0 && o_src_port == 16'd0
         && o_dst_port == 16'd0 && o_window_size == 16'd0 && o_data_offset == 16'd0
         && o_data_length == 16'd0 && o_tcp_flags == 8'd0 && o_header_bytes == 6'd0))
        else $error("fields not zero on a failed verdict");

    a_ok_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_OK) |->
        (o_header_bytes >= MIN_HLEN && o_header_bytes[1:0] == 2'b00
         && o_src_port != 16'd0 && o_dst_port != 16'd0
         && (o_tcp_flags & ~FLAG_MASK) == 8'd0 && (o_tcp_flags & SYN_FIN) != SYN_FIN))
        else $error("passed verdict with an invalid header");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=>
        (!empty && $stable(o_status) && $stable(o_sequence_number)
         && $stable(o_data_length)))
        else $error("stalled result changed");

endmodule

bind tcp_segment_validator_unit tsv_checker u_tsv_checker (.*);

// ===== tb/sv/tb_tcp_segment_validator_unit.sv =====
`timescale 1ns / 1ps
// self-checking testbench for tcp_segment_validator_unit: verdict predictor and scoreboard
// directed frame cases, then random traffic with idling on both queue sides
// depends on tsv_pkg and the tcp_segment_validator_unit rtl
module tb_tcp_segment_validator_unit;
    import tsv_pkg::*;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [15:0] len;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] off;
    } t_seg_byte;

    typedef struct packed {
        t_status     status;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] win;
        logic [15:0] doff;
        logic [15:0] dlen;
        logic [7:0]  flags;
        logic [5:0]  hbytes;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_data_byte;
    logic        i_last;
    logic [15:0] i_segment_length;
    logic [7:0]  i_ip_protocol;
    logic [31:0] i_source_address;
    logic [31:0] i_destination_address;
    logic [15:0] i_ip_payload_offset;
    logic        empty;
    logic        pop;
    logic [1:0]  o_status;
    logic [31:0] o_sequence_number;
    logic [31:0] o_ack_number;
    logic [15:0] o_src_port;
    logic [15:0] o_dst_port;
    logic [15:0] o_window_size;
    logic [15:0] o_data_offset;
    logic [15:0] o_data_length;
    logic [7:0]  o_tcp_flags;
    logic [5:0]  o_header_bytes;

    // predictor state
    logic [15:0] seg_pos = '0;
    logic [31:0] seg_sum = '0;
    logic [7:0]  seg_pend = '0;
    logic [15:0] seg_len = '0;
    logic [7:0]  seg_proto = '0;
    logic [15:0] seg_off = '0;
    logic [7:0]  seg_hdr [16] = '{default: 8'h00};

    t_verdict    expected_verdicts [$];
    t_verdict    head;
    logic [7:0]  seg_buf [$];
    int          mismatches = 0;
    bit          drain = 1'b0;
    int          pop_run = 0;
    int          pop_stall = 0;

    tcp_segment_validator_unit dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .push                  (push),
        .full                  (full),
        .i_data_byte           (i_data_byte),
        .i_last                (i_last),
        .i_segment_length      (i_segment_length),
        .i_ip_protocol         (i_ip_protocol),
        .i_source_address      (i_source_address),
        .i_destination_address (i_destination_address),
        .i_ip_payload_offset   (i_ip_payload_offset),
        .empty                 (empty),
        .pop                   (pop),
        .o_status              (o_status),
        .o_sequence_number     (o_sequence_number),
        .o_ack_number          (o_ack_number),
        .o_src_port            (o_src_port),
        .o_dst_port            (o_dst_port),
        .o_window_size         (o_window_size),
        .o_data_offset         (o_data_offset),
        .o_data_length         (o_data_length),
        .o_tcp_flags           (o_tcp_flags),
        .o_header_bytes        (o_header_bytes)
    );

    always #6 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void absorb_payload_byte(input t_seg_byte s);
        logic [15:0] seen;
        logic [31:0] fold;
        logic [7:0]  b12;
        logic [7:0]  flags;
        logic [5:0]  hl6;
        logic [15:0] hl16;
        logic [15:0] sport;
        logic [15:0] dport;
        t_status     st;
        t_verdict    v;
        if (seg_pos == 16'h0000) begin
            seg_len   = s.len;
            seg_proto = s.proto;
            seg_off   = s.off;
            seg_sum   = {16'h0, s.src[31:16]} + {16'h0, s.src[15:0]} + {16'h0, s.dst[31:16]}
                      + {16'h0, s.dst[15:0]} + {24'h0, PROTO_TCP} + {16'h0, s.len};
            seg_pend  = 8'h00;
            foreach (seg_hdr[k]) seg_hdr[k] = 8'h00;
        end
        if (seg_pos < seg_len) begin
            if (seg_pos[15:4] == 12'h000) seg_hdr[seg_pos[3:0]] = s.data;
            if (!seg_pos[0]) seg_pend = s.data;
            else seg_sum = seg_sum + {16'h0, seg_pend, s.data};
        end
        if (seg_pos != POS_MAX) seg_pos = seg_pos + 16'd1;
        if (!s.last) return;

        seen = (seg_pos < seg_len) ? seg_pos : seg_len;
        fold = seg_sum;
        if (seen[0]) fold = fold + {16'h0, seg_pend, 8'h00};
        repeat (3) fold = {16'h0, fold[15:0]} + {16'h0, fold[31:16]};

        b12   = seg_hdr[12];
        hl6   = {b12[7:4], 2'b00};
        hl16  = {10'h0, hl6};
        sport = {seg_hdr[0], seg_hdr[1]};
        dport = {seg_hdr[2], seg_hdr[3]};
        flags = seg_hdr[13];
        if (seg_proto != PROTO_TCP)
            st = ST_NOT_TCP;
        else if (seg_len < MIN_LEN)
            st = ST_BAD_SIZE;
        else if (hl6 < MIN_HLEN || hl16 > seg_len || (b12 & RSV_MASK) != 8'h00)
            st = ST_BAD_SIZE;
        else if (sport == 16'h0 || dport == 16'h0 || (flags & ~FLAG_MASK) != 8'h00 ||
                 (flags & SYN_FIN) == SYN_FIN || fold[15:0] != CSUM_OK)
            st = ST_INTEGRITY;
        else
            st = ST_OK;

        v = '0;
        v.status = st;
        if (st == ST_OK) begin
            v.seq    = {seg_hdr[4], seg_hdr[5], seg_hdr[6], seg_hdr[7]};
            v.ack    = {seg_hdr[8], seg_hdr[9], seg_hdr[10], seg_hdr[11]};
            v.sport  = sport;
            v.dport  = dport;
            v.win    = {seg_hdr[14], seg_hdr[15]};
            v.doff   = seg_off + hl16;
            v.dlen   = seg_len - hl16;
            v.flags  = flags;
            v.hbytes = hl6;
        end
        expected_verdicts.push_back(v);

        seg_pos  = 16'h0000;
        seg_sum  = 32'h0;
        seg_pend = 8'h00;
        foreach (seg_hdr[k]) seg_hdr[k] = 8'h00;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: verdict expected none actual status %0d", $time, o_status);
                mismatches++;
            end else begin
                head = expected_verdicts.pop_front();
                check_field("status", 32'(head.status), 32'(o_status));
                check_field("sequence_number", head.seq, o_sequence_number);
                check_field("ack_number", head.ack, o_ack_number);
                check_field("src_port", 32'(head.sport), 32'(o_src_port));
                check_field("dst_port", 32'(head.dport), 32'(o_dst_port));
                check_field("window_size", 32'(head.win), 32'(o_window_size));
                check_field("data_offset", 32'(head.doff), 32'(o_data_offset));
                check_field("data_length", 32'(head.dlen), 32'(o_data_length));
                check_field("tcp_flags", 32'(head.flags), 32'(o_tcp_flags));
                check_field("header_bytes", 32'(head.hbytes), 32'(o_header_bytes));
            end
        end
    end

    initial begin : pop_side
        int r;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (drain || pop_run > 0) begin
                pop <= 1'b1;
                if (pop_run > 0) pop_run--;
            end else if (pop_stall > 0) begin
                pop <= 1'b0;
                pop_stall--;
            end else begin
                pop <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 10) pop_run = $urandom_range(20, 80);
                else if (r < 50) pop_stall = pick_gap();
            end
        end
    end

    task automatic idle_input(input int n);
        repeat (n) begin
            @(negedge i_clk);
            push        <= 1'b0;
            i_data_byte <= 8'($urandom);
            i_last      <= 1'($urandom);
        end
    endtask

    task automatic push_request(input t_seg_byte s);
        @(negedge i_clk);
        push                  <= 1'b1;
        i_data_byte           <= s.data;
        i_last                <= s.last;
        i_segment_length      <= s.len;
        i_ip_protocol         <= s.proto;
        i_source_address      <= s.src;
        i_destination_address <= s.dst;
        i_ip_payload_offset   <= s.off;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        absorb_payload_byte(s);
    endtask

    // frame-level fields ride on the first request only, the rest carry junk
    task automatic send_frame(input logic [15:0] len, input logic [7:0] proto,
                              input logic [31:0] src, input logic [31:0] dst,
                              input logic [15:0] off, input bit gappy);
        t_seg_byte s;
        for (int i = 0; i < seg_buf.size(); i++) begin
            s.data = seg_buf[i];
            s.last = (i == seg_buf.size() - 1);
            if (i == 0) begin
                s.len = len; s.proto = proto; s.src = src; s.dst = dst; s.off = off;
            end else begin
                s.len = 16'($urandom); s.proto = 8'($urandom); s.src = $urandom;
                s.dst = $urandom; s.off = 16'($urandom);
            end
            if (gappy) idle_input(pick_gap());
            push_request(s);
        end
    endtask

    task automatic build_segment(input logic [15:0] sport, input logic [15:0] dport,
                                 input logic [31:0] seq, input logic [31:0] ack,
                                 input logic [3:0] words, input logic [7:0] flags,
                                 input logic [15:0] win, input int data_len,
                                 input logic [31:0] src, input logic [31:0] dst);
        int n;
        logic [31:0] sum;
        n = (words < 4'd5) ? 20 : words * 4;
        seg_buf.delete();
        seg_buf.push_back(sport[15:8]); seg_buf.push_back(sport[7:0]);
        seg_buf.push_back(dport[15:8]); seg_buf.push_back(dport[7:0]);
        for (int i = 3; i >= 0; i--) seg_buf.push_back(seq[8*i +: 8]);
        for (int i = 3; i >= 0; i--) seg_buf.push_back(ack[8*i +: 8]);
        seg_buf.push_back({words, 4'h0}); seg_buf.push_back(flags);
        seg_buf.push_back(win[15:8]); seg_buf.push_back(win[7:0]);
        seg_buf.push_back(8'h00); seg_buf.push_back(8'h00);
        seg_buf.push_back(8'($urandom)); seg_buf.push_back(8'($urandom));
        for (int i = 20; i < n + data_len; i++) seg_buf.push_back(8'($urandom));
        sum = {16'h0, src[31:16]} + {16'h0, src[15:0]} + {16'h0, dst[31:16]}
            + {16'h0, dst[15:0]} + {24'h0, PROTO_TCP} + 32'(seg_buf.size());
        for (int i = 0; i < seg_buf.size(); i += 2)
            sum = sum + {16'h0, seg_buf[i], (i + 1 < seg_buf.size()) ? seg_buf[i+1] : 8'h00};
        while (sum[31:16] != 16'h0) sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
        seg_buf[16] = ~sum[15:8];
        seg_buf[17] = ~sum[7:0];
    endtask

    task automatic test_valid_segments();
        build_segment(16'hffff, 16'h0001, 32'hffffffff, 32'h0, 4'd5, 8'h10, 16'hffff, 0,
                      32'hffffffff, 32'h0);
        send_frame(16'(seg_buf.size()), PROTO_TCP, 32'hffffffff, 32'h0, 16'h0000, 1'b0);
        build_segment(16'h0001, 16'hffff, 32'h0, 32'hffffffff, 4'd15, 8'h3e, 16'h0, 7,
                      32'h0, 32'hffffffff);
        send_frame(16'(seg_buf.size()), PROTO_TCP, 32'h0, 32'hffffffff, 16'hffff, 1'b0);
        build_segment(16'h8000, 16'h0050, $urandom, $urandom, 4'd8, 8'h02, 16'h4000, 12,
                      32'hc0a80001, 32'h0a000002);
        send_frame(16'(seg_buf.size()), PROTO_TCP, 32'hc0a80001, 32'h0a000002, 16'h0022,
                   1'b1);
        build_segment(16'h01bb, 16'hc350, $urandom, $urandom, 4'd5, 8'h01, 16'h0200, 5,
                      32'h7f000001, 32'h7f000001);
        send_frame(16'(seg_buf.size()), PROTO_TCP, 32'h7f000001, 32'h7f000001, 16'h000e,
                   1'b0);
    endtask

    task automatic test_not_tcp();
        build_segment(16'h1000, 16'h2000, $urandom, $urandom, 4'd5, 8'h18, 16'h1111, 4,
                      32'h01020304, 32'h05060708);
        send_frame(16'(seg_buf.size()), 8'd17, 32'h01020304, 32'h05060708, 16'h000e, 1'b0);
        send_frame(16'(seg_buf.size()), 8'd0, 32'h01020304, 32'h05060708, 16'h000e, 1'b0);
        send_frame(16'(seg_buf.size()), 8'd255, 32'h01020304, 32'h05060708, 16'h000e, 1'b0);
        // empty payload, one padding byte
        seg_buf.delete();
        seg_buf.push_back(8'h00);
        send_frame(16'd0, 8'd17, 32'h01020304, 32'h05060708, 16'h000e, 1'b0);
    endtask

    task automatic test_bad_size();
        seg_buf.delete();
        seg_buf.push_back(8'hff);
        send_frame(16'd0, PROTO_TCP, 32'h0a000001, 32'h0a000002, 16'h000e, 1'b0);
        build_segment(16'h1000, 16'h2000, $urandom, $urandom, 4'd5, 8'h10, 16'h0100, 0,
                      32'h0a000001, 32'h0a000002);
        while (seg_buf.size() > 19) void'(seg_buf.pop_back());
        send_frame(16'd19, PROTO_TCP, 32'h0a000001, 32'h0a000002, 16'h000e, 1'b0);
        build_segment(16'h1000, 16'h2000, $urandom, $urandom, 4'd4, 8'h10, 16'h0100, 0,
                      32'h0a000001, 32'h0a000002);
        send_frame(16'(seg_buf.size()), PROTO_TCP, 32'h0a000001, 32'h0a000002, 16'h000e,
                   1'b0);
        build_segment(16'h1000, 16'h2000, $urandom, $urandom, 4'd5, 8'h10, 16'h0100, 0,
                      32'h0a000001, 32'h0a000002);
        seg_buf[12] = 8'hb0;
        send_frame(16'(seg_buf.size()), PROTO_TCP, 32'h0a000001, 32'h0a000002, 16'h000e,
                   1'b0);
        seg_buf[12] = 8'h51;
        send_frame(16'(seg_buf.size()), PROTO_TCP, 32'h0a000001, 32'h0a000002, 16'h000e,
                   1'b0);
    endtask

    task automatic test_integrity();
        build_segment(16'h0000, 16'h0050, $urandom, $urandom, 4'd5, 8'h10, 16'h0100, 3,
                      32'hac100001, 32'hac100002);
        send_frame(16'(seg_buf.size()), PROTO_TCP, 32'hac100001, 32'hac100002, 16'h000e,
                   1'b0);
        build_segment(16'h0050, 16'h0000, $urandom, $urandom, 4'd5, 8'h10, 16'h0100, 3,
                      32'hac100001, 32'hac100002);
        send_frame(16'(seg_buf.size()), PROTO_TCP, 32'hac100001, 32'hac100002, 16'h000e,
                   1'b0);
        build_segment(16'h0050, 16'h0051, $urandom, $urandom, 4'd5, 8'h40, 16'h0100, 3,
                      32'hac100001, 32'hac100002);
        send_frame(16'(seg_buf.size()), PROTO_TCP, 32'hac100001, 32'hac100002, 16'h000e,
                   1'b0);
        build_segment(16'h0050, 16'h0051, $urandom, $urandom, 4'd5, 8'h80, 16'h0100, 3,
                      32'hac100001, 32'hac100002);
        send_frame(16'(seg_buf.size()), PROTO_TCP, 32'hac100001, 32'hac100002, 16'h000e,
                   1'b0);
        build_segment(16'h0050, 16'h0051, $urandom, $urandom, 4'd5, 8'h03, 16'h0100, 3,
                      32'hac100001, 32'hac100002);
        send_frame(16'(seg_buf.size()), PROTO_TCP, 32'hac100001, 32'hac100002, 16'h000e,
                   1'b0);
        build_segment(16'h0050, 16'h0051, $urandom, $urandom, 4'd5, 8'h18, 16'h0100, 3,
                      32'hac100001, 32'hac100002);
        seg_buf[17] = seg_buf[17] ^ 8'h01;
        send_frame(16'(seg_buf.size()), PROTO_TCP, 32'hac100001, 32'hac100002, 16'h000e,
                   1'b0);
    endtask

    task automatic test_frame_edges();
        logic [15:0] len;
        // trailing bytes past the length are ignored
        build_segment(16'h0400, 16'h0401, $urandom, $urandom, 4'd6, 8'h10, 16'h0800, 4,
                      32'h0b0b0b0b, 32'h0c0c0c0c);
        len = 16'(seg_buf.size());
        repeat (6) seg_buf.push_back(8'($urandom));
        send_frame(len, PROTO_TCP, 32'h0b0b0b0b, 32'h0c0c0c0c, 16'h000e, 1'b0);
        // frame closed early, full header seen
        build_segment(16'h0400, 16'h0401, $urandom, $urandom, 4'd5, 8'h10, 16'h0800, 20,
                      32'h0b0b0b0b, 32'h0c0c0c0c);
        while (seg_buf.size() > 31) void'(seg_buf.pop_back());
        send_frame(16'd40, PROTO_TCP, 32'h0b0b0b0b, 32'h0c0c0c0c, 16'h000e, 1'b0);
        // frame closed early inside the header
        while (seg_buf.size() > 7) void'(seg_buf.pop_back());
        send_frame(16'd40, PROTO_TCP, 32'h0b0b0b0b, 32'h0c0c0c0c, 16'h000e, 1'b0);
        // maximum length, closed early
        build_segment(16'h1234, 16'h0050, $urandom, $urandom, 4'd5, 8'h10, 16'h2000, 10,
                      32'hc0000201, 32'hc6336402);
        send_frame(16'hffff, PROTO_TCP, 32'hc0000201, 32'hc6336402, 16'h000e, 1'b0);
    endtask

    task automatic test_random_traffic();
        int          kind;
        int          idx;
        int          bytes_sent;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] off;
        logic [15:0] len;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [7:0]  proto;
        logic [7:0]  flags;
        logic [3:0]  words;
        bytes_sent  = 0;
        while (bytes_sent < 400) begin
            src   = $urandom;
            dst   = $urandom;
            off   = 16'($urandom);
            kind  = $urandom_range(0, 99);
            proto = ($urandom_range(0, 19) == 0) ? 8'($urandom) : PROTO_TCP;
            sp    = ($urandom_range(0, 39) == 0) ? 16'h0 : 16'($urandom_range(1, 65535));
            dp    = ($urandom_range(0, 39) == 0) ? 16'h0 : 16'($urandom_range(1, 65535));
            words = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
            flags = 8'($urandom_range(0, 63));
            if (flags[1:0] == 2'b11 && $urandom_range(0, 3) != 0) flags[0] = 1'b0;
            if ($urandom_range(0, 19) == 0) flags = 8'($urandom);
            if (kind < 90) begin
                build_segment(sp, dp, $urandom, $urandom, words, flags, 16'($urandom),
                              $urandom_range(0, 12), src, dst);
                len = 16'(seg_buf.size());
                if (kind < 70 && $urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 6)) seg_buf.push_back(8'($urandom));
                if (kind >= 70 && kind < 80) begin
                    idx = $urandom_range(0, seg_buf.size() - 1);
                    seg_buf[idx] = seg_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
                end
                if (kind >= 80) begin
                    idx = $urandom_range(1, seg_buf.size() - 1);
                    while (seg_buf.size() > idx) void'(seg_buf.pop_back());
                end
            end else begin
                seg_buf.delete();
                repeat ($urandom_range(1, 40)) seg_buf.push_back(8'($urandom));
                len   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 48));
                proto = ($urandom_range(0, 3) == 0) ? PROTO_TCP : 8'($urandom);
            end
            send_frame(len, proto, src, dst, off, $urandom_range(0, 3) != 0);
            bytes_sent  += seg_buf.size();
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        push                  = 1'b0;
        i_data_byte           = 8'h00;
        i_last                = 1'b0;
        i_segment_length      = 16'h0;
        i_ip_protocol         = 8'h00;
        i_source_address      = 32'h0;
        i_destination_address = 32'h0;
        i_ip_payload_offset   = 16'h0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_valid_segments();
        test_not_tcp();
        test_bad_size();
        test_integrity();
        test_frame_edges();
        test_random_traffic();

        idle_input(1);
        drain = 1'b1;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #24000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
